>>> hdl/ffpra_pkg.sv
`default_nettype none
package ffpra_pkg;

   localparam int DEFAULT_MAX_REGIONS = 16;

   localparam int ADDR_W  = 48;
   localparam int PAGES_W = 36;
   localparam int PAGE_SHIFT = 12;   // 4096-byte pages

   // request kinds (tuser bit 0 on the request side)
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_ALLOC  = 1'b1;

   // result status codes (tuser on the response side)
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NO_FIT = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;

   // request token walking down the region cells
   typedef struct packed {
      logic                 valid;
      logic                 kind;
      logic [ADDR_W-1:0]    start;
      logic [PAGES_W-1:0]   pages;
      logic [PAGES_W-1:0]   used;
      logic [PAGES_W-1:0]   want;
      logic                 done;
      logic [ADDR_W-1:0]    addr;
      logic [1:0]           status;
   } tok_type;

endpackage
`default_nettype wire

>>> hdl/ffpra_cell.sv
`default_nettype none
module ffpra_cell
   import ffpra_pkg::*;
#(
   parameter int CNT_W = 5,
   parameter int INDEX = 0
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire logic [CNT_W-1:0] region_count,
   input  wire tok_type          tok_i,
   output tok_type               tok_o
);

   localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

   logic [ADDR_W-1:0]  start_ff;
   logic [PAGES_W-1:0] size_ff;
   logic [PAGES_W-1:0] used_ff;
   tok_type            tok_ff, tok_in;

   logic               live, occupied, fits, hit_ins, hit_alloc;
   logic [PAGES_W:0]   sum;
   logic [ADDR_W-1:0]  addr;

   always_comb begin
      live     = tok_i.valid && !tok_i.done;
      occupied = MY_IDX < region_count;
      // full-precision fit test, the sum cannot wrap
      sum      = {1'b0, used_ff} + {1'b0, tok_i.want};
      fits     = occupied && (sum <= {1'b0, size_ff});
      addr     = start_ff + {used_ff, {PAGE_SHIFT{1'b0}}};
      hit_ins   = live && (tok_i.kind == REQ_INSERT) && (region_count == MY_IDX);
      hit_alloc = live && (tok_i.kind == REQ_ALLOC) && fits;

      tok_in = tok_i;
      if (hit_ins || hit_alloc) begin
         tok_in.done   = 1'b1;
         tok_in.status = ST_OK;
         tok_in.addr   = hit_alloc ? addr : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (hit_ins) begin
            start_ff <= tok_i.start;
            size_ff  <= tok_i.pages;
            used_ff  <= tok_i.used;
         end else if (hit_alloc) begin
            used_ff  <= sum[PAGES_W-1:0];
         end
      end
   end

   assign tok_o = tok_ff;

endmodule
`default_nettype wire

>>> hdl/first_fit_page_region_allocator.sv
`default_nettype none
// first-fit page region allocator
//
// request channel (req_*): one transfer per request. req_tuser[0] picks the kind:
// insert appends a region (start, size in pages, pages already used), allocate
// asks for a number of pages. response channel (rsp_*): exactly one transfer per
// request, carrying the block address and a status (ok, no region fits, table full).
//
// each region lives in one cell of a chain of MAX_REGIONS cells. a request enters
// an input register and then walks the chain one cell per cycle while the chain is
// not stalled, oldest region first; the first cell that can serve it marks the token
// done and updates its own region. from the last cell the result moves into the
// output register that drives rsp_tvalid. a new request is taken once the previous
// result has left the chain, so only one request is in the chain at a time.
//
// reset empties the region table at once (the region count goes to zero; cell
// contents are not cleared). a stalled receiver holds the result in the output
// register; the next request may enter and walk the chain, and it waits in the
// last cell until the output register is free.
module first_fit_page_region_allocator
   import ffpra_pkg::*;
#(
   parameter int MAX_REGIONS = DEFAULT_MAX_REGIONS
) (
   input  wire logic         clock,
   input  wire logic         reset,

   input  wire logic         req_tvalid,
   output logic              req_tready,
   // [47:0] region_start, [83:48] region_pages, [119:84] used_at_insert,
   // [155:120] alloc_pages, [159:156] zero
   input  wire logic [159:0] req_tdata,
   // [0] req_type
   input  wire logic [0:0]   req_tuser,

   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [47:0] alloc_addr
   output logic [47:0]       rsp_tdata,
   // [1:0] status
   output logic [1:0]        rsp_tuser
);

   localparam int CNT_W = $clog2(MAX_REGIONS + 1);

   // tok[0] is the input register, tok[i+1] the output of cell i
   tok_type            tok [MAX_REGIONS+1];
   tok_type            tok0_ff, tok0_in;
   tok_type            last;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic               busy_ff, busy_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   logic               accept, advance, finish;

   assign last    = tok[MAX_REGIONS];
   // the chain freezes only while a finished token waits for a full output register
   assign advance = !(last.valid && rsp_valid_ff && !rsp_tready);
   assign finish  = last.valid && advance;
   assign accept  = req_tvalid && req_tready;
   assign req_tready = !busy_ff;

   always_comb begin
      tok0_in = tok0_ff;
      if (accept) begin
         tok0_in.valid  = 1'b1;
         tok0_in.kind   = req_tuser[0];
         tok0_in.start  = req_tdata[47:0];
         tok0_in.pages  = req_tdata[83:48];
         tok0_in.used   = req_tdata[119:84];
         tok0_in.want   = req_tdata[155:120];
         tok0_in.done   = 1'b0;
         tok0_in.addr   = '0;
         tok0_in.status = ST_OK;
      end else if (advance) begin
         tok0_in.valid  = 1'b0;
      end
   end

   assign tok[0] = tok0_ff;

   for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
      ffpra_cell #(
         .CNT_W (CNT_W),
         .INDEX (i)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .advance      (advance),
         .region_count (count_ff),
         .tok_i        (tok[i]),
         .tok_o        (tok[i+1])
      );
   end

   always_comb begin
      count_in      = count_ff;
      busy_in       = busy_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;

      if (accept) begin
         busy_in = 1'b1;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         if (last.done) begin
            rsp_addr_in   = last.addr;
            rsp_status_in = last.status;
            // a completed insert took the cell at the current count
            if (last.kind == REQ_INSERT) begin
               count_in = count_ff + CNT_W'(1);
            end
         end else begin
            rsp_addr_in   = '0;
            rsp_status_in = (last.kind == REQ_INSERT) ? ST_FULL : ST_NO_FIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok0_ff.valid <= 1'b0;
         count_ff      <= '0;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         tok0_ff       <= tok0_in;
         count_ff      <= count_in;
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_addr_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule
`default_nettype wire

>>> hdl/ffpra_checker.sv
`default_nettype none
module ffpra_checker
   import ffpra_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [47:0]  rsp_tdata,
   input wire logic [1:0]   rsp_tuser
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // only the three defined status codes appear
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == ST_OK) || (rsp_tuser == ST_NO_FIT) ||
                     (rsp_tuser == ST_FULL))
      else $error("undefined status code");

   // failed requests carry a zero address
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> rsp_tdata == '0)
      else $error("nonzero address on failed request");

   // one request at a time: the input closes right after a transfer
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while busy");

   // no response right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind first_fit_page_region_allocator ffpra_checker u_ffpra_checker (.*);
`default_nettype wire
